[hw/rtl/wide_unsigned_arith_unit_assert.svh]
// assertion macros for the wide unsigned arithmetic unit
// no dependencies; included by the modules that check their own logic
`ifndef WIDE_UNSIGNED_ARITH_UNIT_ASSERT_SVH
`define WIDE_UNSIGNED_ARITH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define WUAU_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wuau assertion failed");
`define WUAU_NEVER(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) \
    else $error("wuau forbidden condition seen");
`else
`define WUAU_ASSERT(lbl, clk, rst, prop)
`define WUAU_NEVER(lbl, clk, rst, prop)
`endif
`endif

[hw/rtl/wuau_pkg.sv]
// shared widths, operation codes and types for the wide unsigned arithmetic unit
// no dependencies; imported by wuau_addsub, wide_unsigned_arith_unit and tb_top
package wuau_pkg;

  localparam int W          = 96;
  localparam int AW         = W + 1;
  localparam int LAST       = W - 1;
  localparam int CNT_W      = $clog2(W);
  localparam int DATA_IN_W  = 2 * W;
  localparam int DATA_OUT_W = ((2 * W + 2 + 7) / 8) * 8;
  localparam int KIND_W     = 2;

  localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 2'd3;

  typedef struct packed {
    logic sub;
  } alu_ctrl_t;

  typedef struct packed {
    logic carry;
  } alu_stat_t;

endpackage

[hw/rtl/wide_unsigned_arith_unit.sv]
// top level of the wide unsigned arithmetic unit: sequencer, operand registers
// and output register around one shared adder; depends on wuau_pkg, wuau_addsub
//
// usage:
//   s_axis carries one request per beat: tuser is the operation kind
//   (add, subtract, multiply, divide), tdata the two 96-bit operands.
//   m_axis returns one result per request: quotient or result, remainder,
//   carry/borrow/overflow flag and divide-by-zero flag.
//   the block works on one request at a time and drops s_axis_tready while
//   busy. add, subtract and divide by zero take one step in the unit;
//   multiply and divide take 96 steps, one operand bit per cycle through
//   the shared 97-bit adder.
//   the result appears on m_axis the cycle after the last step.
//   m_axis is a register: while a result waits the next request is taken
//   and computed, and its last step holds until the output register frees.
//   rst clears the sequencer and the output valid; no request is lost or
//   repeated under any stall pattern on m_axis_tready.
`include "wide_unsigned_arith_unit_assert.svh"
module wide_unsigned_arith_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // operand_a_low, operand_a_high, operand_b_low, operand_b_high
  input  logic [wuau_pkg::DATA_IN_W-1:0]      s_axis_tdata,
  // kind
  input  logic [wuau_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // result_low, result_high, remainder_low, remainder_high, carry_out,
  // divide_by_zero, zero fill
  output logic [wuau_pkg::DATA_OUT_W-1:0]     m_axis_tdata
);
  import wuau_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state;
  logic [KIND_W-1:0] kind;
  logic [W-1:0]      opa;
  logic [W-1:0]      opb;
  logic [W-1:0]      acc;
  logic [W-1:0]      quo;
  logic              ovf;
  logic [CNT_W-1:0]  cnt;

  logic [W-1:0]      acc_next;
  logic [W-1:0]      quo_next;
  logic              ovf_next;

  alu_ctrl_t         ctrl;
  alu_stat_t         stat;
  logic [AW-1:0]     x;
  logic [AW-1:0]     y;
  logic [AW-1:0]     sum;

  logic              bit_in;
  logic              dz;
  logic              last;
  logic              out_free;
  logic              fire;
  logic              load_out;
  logic [W-1:0]      res_val;
  logic [W-1:0]      rem_val;
  logic              flag_val;

  wuau_addsub u_addsub (
    .ctrl (ctrl),
    .x    (x),
    .y    (y),
    .sum  (sum),
    .stat (stat)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign bit_in        = quo[W-1];
  assign dz            = (kind == KIND_DIV) && (opb == '0);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign last          = (kind == KIND_ADD) || (kind == KIND_SUB) || dz ||
                         (cnt == CNT_W'(LAST));
  assign fire          = (state == ST_RUN) && (!last || out_free);
  assign load_out      = fire && last;

  always_comb begin
    ctrl.sub = 1'b0;
    x        = {1'b0, opa};
    y        = {1'b0, opb};
    acc_next = acc;
    quo_next = quo;
    ovf_next = ovf;
    res_val  = '0;
    rem_val  = '0;
    flag_val = 1'b0;
    case (kind)
      KIND_ADD: begin
        res_val  = sum[W-1:0];
        flag_val = stat.carry | sum[W];
      end
      KIND_SUB: begin
        ctrl.sub = 1'b1;
        res_val  = sum[W-1:0];
        flag_val = sum[W];
      end
      KIND_MUL: begin
        x        = {1'b0, acc[W-2:0], 1'b0};
        y        = bit_in ? {1'b0, opa} : '0;
        ovf_next = ovf | acc[W-1] | sum[W];
        acc_next = sum[W-1:0];
        quo_next = {quo[W-2:0], 1'b0};
        res_val  = ovf_next ? '0 : sum[W-1:0];
        flag_val = ovf_next;
      end
      default: begin
        ctrl.sub = 1'b1;
        x        = {acc, bit_in};
        acc_next = sum[W] ? x[W-1:0] : sum[W-1:0];
        quo_next = {quo[W-2:0], ~sum[W]};
        res_val  = dz ? '0 : quo_next;
        rem_val  = dz ? opa : acc_next;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        state <= ST_RUN;
        cnt   <= '0;
      end else if (fire) begin
        cnt <= cnt + CNT_W'(1);
        if (last) begin
          state <= ST_IDLE;
        end
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind <= s_axis_tuser;
      opa  <= s_axis_tdata[W-1:0];
      opb  <= s_axis_tdata[2*W-1:W];
      acc  <= '0;
      ovf  <= 1'b0;
      quo  <= (s_axis_tuser == KIND_MUL) ? s_axis_tdata[2*W-1:W] : s_axis_tdata[W-1:0];
    end else if (fire) begin
      acc <= acc_next;
      quo <= quo_next;
      ovf <= ovf_next;
    end
    if (load_out) begin
      m_axis_tdata <= {(DATA_OUT_W-2*W-2)'(0), dz, flag_val, rem_val, res_val};
    end
  end

  `WUAU_ASSERT(a_accept_starts, clk, rst, s_axis_tvalid && s_axis_tready |=> state == ST_RUN)
  `WUAU_NEVER(a_cnt_range, clk, rst, state == ST_RUN && cnt > CNT_W'(LAST))
  `WUAU_ASSERT(a_dz_zero_quo, clk, rst, m_axis_tvalid && m_axis_tdata[2*W+1] |-> m_axis_tdata[W-1:0] == '0 && !m_axis_tdata[2*W])
  `WUAU_ASSERT(a_out_after_step, clk, rst, $rose(m_axis_tvalid) |-> $past(state) == ST_RUN)

endmodule

[hw/rtl/wuau_addsub.sv]
// shared 97-bit adder/subtractor used by every operation step
// depends on wuau_pkg
module wuau_addsub (
  input  wuau_pkg::alu_ctrl_t      ctrl,
  input  logic [wuau_pkg::AW-1:0]  x,
  input  logic [wuau_pkg::AW-1:0]  y,
  output logic [wuau_pkg::AW-1:0]  sum,
  output wuau_pkg::alu_stat_t      stat
);
  import wuau_pkg::*;

  logic [AW:0] full;

  always_comb begin
    full = {1'b0, x} + {1'b0, (ctrl.sub ? ~y : y)} + (AW+1)'(ctrl.sub);
  end

  assign sum        = full[AW-1:0];
  assign stat.carry = full[AW];

endmodule

[tb/tb_top.sv]
// testbench for wide_unsigned_arith_unit: directed and random add, subtract,
// multiply and divide requests, each result checked against a local predictor or
// a directed expected value; depends on wuau_pkg and the wide_unsigned_arith_unit rtl
`timescale 1ns / 1ps

module tb_top;
  import wuau_pkg::*;

  localparam logic [95:0] ONES = {96{1'b1}};
  localparam logic [95:0] ONE = 96'd1;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 250;
  localparam int ITEMS_PER_PHASE = 308;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [95:0] a;
    logic [95:0] b;
  } arith_req_t;

  typedef struct packed {
    logic [95:0] value;
    logic [95:0] rem;
    logic carry;
    logic dz;
  } arith_res_t;

  typedef struct {
    arith_req_t req;
    bit typed;
    arith_res_t res;
  } directed_row_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [DATA_IN_W-1:0] s_axis_tdata;
  logic [KIND_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [DATA_OUT_W-1:0] m_axis_tdata;

  arith_res_t expected_results[$];
  directed_row_t directed_rows[$];
  int error_count = 0;
  int stall_cycles = 0;
  int send_idle_pct;
  int recv_idle_pct;

  wide_unsigned_arith_unit uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic arith_res_t predict_arith(arith_req_t r);
    arith_res_t e;
    logic [96:0] sum;
    logic [191:0] prod;
    e = '0;
    case (r.kind)
      KIND_ADD: begin
        sum = {1'b0, r.a} + {1'b0, r.b};
        e.value = sum[95:0];
        e.carry = sum[96];
      end
      KIND_SUB: begin
        e.value = r.a - r.b;
        e.carry = (r.a < r.b);
      end
      KIND_MUL: begin
        prod = {96'd0, r.a} * {96'd0, r.b};
        if (prod[191:96] != '0) begin
          e.carry = 1'b1;
        end else begin
          e.value = prod[95:0];
        end
      end
      default: begin
        if (r.b == '0) begin
          e.dz = 1'b1;
          e.rem = r.a;
        end else begin
          e.value = r.a / r.b;
          e.rem = r.a % r.b;
        end
      end
    endcase
    return e;
  endfunction

  // zero, all ones below max_bits, a single bit, or random bits below a random width
  function automatic logic [95:0] rand_operand(int unsigned max_bits);
    logic [95:0] v;
    int unsigned shape;
    int unsigned nbits;
    v = {$urandom(), $urandom(), $urandom()};
    shape = $urandom_range(9);
    case (shape)
      0: v = '0;
      1: v = ONES >> (96 - max_bits);
      2: v = ONE << $urandom_range(max_bits - 1);
      default: begin
        nbits = $urandom_range(max_bits, 1);
        v = v & (ONES >> (96 - nbits));
      end
    endcase
    return v;
  endfunction

  function automatic arith_req_t random_request();
    arith_req_t r;
    int unsigned kind_sel;
    int unsigned bits_a;
    kind_sel = $urandom_range(3);
    r.kind = kind_sel[KIND_W-1:0];
    case (r.kind)
      KIND_MUL: begin
        // widths near the 96-bit boundary so products mostly just fit
        bits_a = $urandom_range(96, 1);
        r.a = rand_operand(bits_a);
        if ($urandom_range(3) == 0) begin
          r.b = rand_operand(96);
        end else begin
          r.b = rand_operand(97 - bits_a);
        end
      end
      KIND_DIV: begin
        r.a = rand_operand(96);
        r.b = rand_operand($urandom_range(96, 1));
      end
      default: begin
        r.a = rand_operand(96);
        r.b = rand_operand(96);
        if ($urandom_range(7) == 0) begin
          r.b = r.a;
        end
      end
    endcase
    return r;
  endfunction

  task automatic dir_row(logic [KIND_W-1:0] kind, logic [95:0] a, logic [95:0] b,
                         bit typed, logic [95:0] value, logic [95:0] rem,
                         logic carry, logic dz);
    directed_row_t row;
    row.req.kind = kind;
    row.req.a = a;
    row.req.b = b;
    row.typed = typed;
    row.res.value = value;
    row.res.rem = rem;
    row.res.carry = carry;
    row.res.dz = dz;
    directed_rows.push_back(row);
  endtask

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_request(arith_req_t r, bit typed, arith_res_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.kind;
    s_axis_tdata <= {r.b, r.a};
    do begin
      @(posedge clk);
    end while (!(s_axis_tvalid && s_axis_tready));
    expected_results.push_back(typed ? typed_res : predict_arith(r));
  endtask

  task automatic report_mismatch(string field, logic [95:0] exp_v, logic [95:0] got_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, got_v);
    error_count++;
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    arith_res_t exp_r;
    arith_res_t got_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_r.value = m_axis_tdata[95:0];
      got_r.rem = m_axis_tdata[191:96];
      got_r.carry = m_axis_tdata[192];
      got_r.dz = m_axis_tdata[193];
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending, actual %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got_r.value !== exp_r.value) report_mismatch("result", exp_r.value, got_r.value);
        if (got_r.rem !== exp_r.rem) report_mismatch("remainder", exp_r.rem, got_r.rem);
        if (got_r.carry !== exp_r.carry) begin
          report_mismatch("carry_out", 96'(exp_r.carry), 96'(got_r.carry));
        end
        if (got_r.dz !== exp_r.dz) begin
          report_mismatch("divide_by_zero", 96'(exp_r.dz), 96'(got_r.dz));
        end
        if (m_axis_tdata[DATA_OUT_W-1:194] !== '0) begin
          report_mismatch("fill", '0, 96'(m_axis_tdata[DATA_OUT_W-1:194]));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    arith_res_t no_res;
    int phase;
    no_res = '0;
    send_idle_pct = 7;
    recv_idle_pct = 79;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = KIND_ADD;
    m_axis_tready = 1'b0;

    // extremes, carries across word boundaries, overflow and divide corners
    dir_row(KIND_ADD, '0, '0, 1, '0, '0, 0, 0);
    dir_row(KIND_ADD, ONES, ONE, 1, '0, '0, 1, 0);
    dir_row(KIND_ADD, ONES, ONES, 1, ONES - ONE, '0, 1, 0);
    dir_row(KIND_ADD, ONES >> 32, ONE, 1, ONE << 64, '0, 0, 0);
    dir_row(KIND_SUB, '0, '0, 1, '0, '0, 0, 0);
    dir_row(KIND_SUB, '0, ONE, 1, ONES, '0, 1, 0);
    dir_row(KIND_SUB, ONES, ONES, 1, '0, '0, 0, 0);
    dir_row(KIND_SUB, ONE << 64, ONE, 1, ONES >> 32, '0, 0, 0);
    dir_row(KIND_MUL, '0, ONES, 1, '0, '0, 0, 0);
    dir_row(KIND_MUL, ONES, ONE, 1, ONES, '0, 0, 0);
    dir_row(KIND_MUL, ONE << 48, ONE << 48, 1, '0, '0, 1, 0);
    dir_row(KIND_MUL, ONE << 47, ONE << 48, 1, ONE << 95, '0, 0, 0);
    dir_row(KIND_MUL, ONES, ONES, 1, '0, '0, 1, 0);
    dir_row(KIND_MUL, 96'h0000_0000_1234_5678_9abc_def0, 96'h0000_0000_0fed_cba9,
            0, '0, '0, 0, 0);
    dir_row(KIND_MUL, ONES >> 48, ONES >> 48, 0, '0, '0, 0, 0);
    dir_row(KIND_DIV, ONES, '0, 1, '0, ONES, 0, 1);
    dir_row(KIND_DIV, '0, '0, 1, '0, '0, 0, 1);
    dir_row(KIND_DIV, 96'd5, 96'd7, 1, '0, 96'd5, 0, 0);
    dir_row(KIND_DIV, ONES, ONE, 1, ONES, '0, 0, 0);
    dir_row(KIND_DIV, ONES, ONES, 1, ONE, '0, 0, 0);
    dir_row(KIND_DIV, 96'd100, 96'd7, 1, 96'd14, 96'd2, 0, 0);
    dir_row(KIND_DIV, 96'hfedc_ba98_7654_3210_0123_4567, 96'h0000_0001_0000_0000_0000_0003,
            0, '0, '0, 0, 0);
    dir_row(KIND_DIV, ONES, ONE << 95, 0, '0, '0, 0, 0);
    dir_row(KIND_ADD, 96'h8000_0000_ffff_ffff_ffff_ffff, 96'h7fff_ffff_0000_0000_0000_0001,
            0, '0, '0, 0, 0);
    dir_row(KIND_SUB, 96'h0000_0001_0000_0000_0000_0000, 96'h0000_0000_ffff_ffff_ffff_ffff,
            0, '0, '0, 0, 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    end

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_request(random_request(), 0, no_res);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
